/* rtl/core/lmts_pkg.sv */
// Shared types and constants for the LED matrix text scroller.
// Holds command and register codes plus the controller/datapath interface structs.
// No dependencies.
package lmts_pkg;

    // Sizes of the stores and the frame.
    localparam int MAX_CHARS   = 32;
    localparam int FRAME_ROWS  = 16;
    localparam int GLYPH_COUNT = 96;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_COLS;

    localparam int MSG_AW    = $clog2(MAX_CHARS);
    localparam int FONT_AW   = $clog2(FONT_DEPTH);
    localparam int ROW_W     = $clog2(FRAME_ROWS);
    localparam int POS_W     = 10;
    localparam int LEN_W     = 6;
    localparam int TOTAL_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    // Input commands.
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_RESTART   = 2'd1;
    localparam logic [1:0] CMD_LOAD_MSG  = 2'd2;
    localparam logic [1:0] CMD_LOAD_FONT = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_VERTICAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LENGTH  = 2'd3;

    // Scroll positions that the block restarts from (-7 and -16).
    localparam logic [POS_W-1:0] POS_START_H = 10'h3F9;
    localparam logic [POS_W-1:0] POS_START_V = 10'h3F0;
    localparam logic [POS_W-1:0] POS_LEAD_H  = 10'd8;
    localparam logic [POS_W-1:0] POS_LEAD_V  = 10'd16;

    // Character code limits.
    localparam logic [7:0] CHAR_FIRST   = 8'd32;
    localparam logic [7:0] CHAR_LAST    = 8'd127;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [7:0] CASE_FOLD    = 8'd32;

    // floor(u * 171 / 1024) equals floor(u / 6) for every u below 256.
    localparam logic [7:0] DIV6_RECIP = 8'd171;
    localparam int         DIV6_SHIFT = 10;

    localparam logic [2:0] H_SPACER = 3'd5;
    localparam logic [2:0] V_SPACER = 3'd7;

    typedef struct packed {
        logic write_msg;
        logic write_font;
        logic start_render;
        logic issue_slot;
        logic advance;
        logic restart;
        logic emit_row;
    } lmts_cmd_t;

    typedef struct packed {
        logic last_slot;
        logic pipe_busy;
        logic out_free;
        logic last_emit;
    } lmts_status_t;

endpackage

/* rtl/core/lmts_ctrl.sv */
// Controller state machine of the LED matrix text scroller.
// Sequences input acceptance, rendering, position update and frame emission.
// Depends on lmts_pkg.
module lmts_ctrl
    import lmts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   command,
    input  lmts_status_t status,
    output lmts_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RENDER = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_TICK:
                        begin
                            cmd.start_render = 1'b1;
                            state_next       = ST_RENDER;
                        end
                        CMD_RESTART:
                        begin
                            cmd.restart = 1'b1;
                            state_next  = ST_EMIT;
                        end
                        CMD_LOAD_MSG:  cmd.write_msg  = 1'b1;
                        CMD_LOAD_FONT: cmd.write_font = 1'b1;
                        default:       cmd.write_font = 1'b1;
                    endcase
                end
            end
            ST_RENDER:
            begin
                cmd.issue_slot = 1'b1;
                if (status.last_slot)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The position may move only after the last frame write lands.
                if (!status.pipe_busy)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_row = 1'b1;
                    if (status.last_emit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

/* rtl/core/lmts_datapath.sv */
// Datapath of the LED matrix text scroller: configuration registers, message
// and font memories, a three-stage render pipeline, the frame and the output register.
// Depends on lmts_pkg; driven by lmts_ctrl.
module lmts_datapath
    import lmts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lmts_cmd_t            cmd,
    output lmts_status_t         status,
    input  logic [8:0]           index,
    input  logic [7:0]           data_byte,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ROW_W-1:0]     row_number,
    output logic [7:0]           row_bits,
    output logic                 last_row
);

    // Configuration.
    logic             vertical_reg;
    logic [3:0]       row_offset_reg;
    logic [1:0]       column_offset_reg;
    logic [LEN_W-1:0] length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertical_reg      <= 1'b0;
            row_offset_reg    <= 4'd5;
            column_offset_reg <= 2'd2;
            length_reg        <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SCROLL_VERTICAL: vertical_reg      <= cfg_data[0];
                CFG_ROW_OFFSET:      row_offset_reg    <= cfg_data[3:0];
                CFG_COLUMN_OFFSET:   column_offset_reg <= cfg_data[1:0];
                CFG_MESSAGE_LENGTH:  length_reg        <= cfg_data[LEN_W-1:0];
                default:             vertical_reg      <= vertical_reg;
            endcase
        end
    end

    logic [LEN_W-1:0]   used_len;
    logic [TOTAL_W-1:0] total;
    logic [POS_W-1:0]   bound;

    assign used_len = (length_reg > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : length_reg;
    assign total    = vertical_reg ? {used_len, 3'b000}
                                   : TOTAL_W'({used_len, 2'b00}) + TOTAL_W'({used_len, 1'b0});
    assign bound    = {1'b0, total} + (vertical_reg ? POS_LEAD_V : POS_LEAD_H);

    // Scroll position.
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_inc;
    logic             pos_wrap;

    assign pos_inc  = pos_reg + POS_W'(1);
    assign pos_wrap = $signed({pos_inc[POS_W-1], pos_inc}) >= $signed({1'b0, bound});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_START_H;
        end
        else if (cmd.restart)
        begin
            pos_reg <= POS_START_H;
        end
        else if (cmd.advance)
        begin
            pos_reg <= pos_wrap ? (vertical_reg ? POS_START_V : POS_START_H) : pos_inc;
        end
    end

    // Slot counters: a slot is one frame column (horizontal) or one glyph
    // column of one frame row (vertical).
    logic [ROW_W-1:0] slot_i_reg;
    logic [2:0]       slot_j_reg;
    logic             j_last;

    assign j_last           = (slot_j_reg == 3'(GLYPH_COLS - 1));
    assign status.last_slot = vertical_reg ? (j_last && (slot_i_reg == ROW_W'(FRAME_ROWS - 1)))
                                           : (slot_i_reg == ROW_W'(7));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_i_reg <= '0;
            slot_j_reg <= '0;
        end
        else if (cmd.start_render)
        begin
            slot_i_reg <= '0;
            slot_j_reg <= '0;
        end
        else if (cmd.issue_slot)
        begin
            if (!vertical_reg || j_last)
            begin
                slot_i_reg <= slot_i_reg + ROW_W'(1);
                slot_j_reg <= '0;
            end
            else
            begin
                slot_j_reg <= slot_j_reg + 3'd1;
            end
        end
    end

    // Stage A: slice position, range test, split into character and sub-position.
    logic [POS_W-1:0]  s_pos;
    logic              in_range;
    logic [7:0]        u8;
    logic [15:0]       div_prod;
    logic [5:0]        q_h;
    logic [7:0]        rem_h;
    logic [2:0]        sub_h;
    logic [MSG_AW-1:0] msg_raddr;
    logic              zero_a;

    assign s_pos     = pos_reg + POS_W'(slot_i_reg);
    assign in_range  = !s_pos[POS_W-1] && (s_pos[TOTAL_W-1:0] < total);
    assign u8        = s_pos[7:0];
    assign div_prod  = u8 * DIV6_RECIP;
    assign q_h       = div_prod[15:DIV6_SHIFT];
    assign rem_h     = u8 - (8'({q_h, 2'b00}) + 8'({q_h, 1'b0}));
    assign sub_h     = rem_h[2:0];
    assign msg_raddr = vertical_reg ? u8[7:3] : q_h[MSG_AW-1:0];
    assign zero_a    = !in_range || (vertical_reg ? (u8[2:0] == V_SPACER) : (sub_h == H_SPACER));

    logic             a_valid_reg;
    logic             a_zero_row_reg;
    logic [2:0]       a_fcol_reg;
    logic [2:0]       a_bit_reg;
    logic [ROW_W-1:0] a_row_reg;

    logic [7:0] msg_mem [MAX_CHARS];
    logic [7:0] msg_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_msg && (index < 9'(MAX_CHARS)))
        begin
            msg_mem[index[MSG_AW-1:0]] <= data_byte;
        end
        msg_rdata_reg <= msg_mem[msg_raddr];
    end

    always_ff @(posedge clk)
    begin
        a_zero_row_reg <= zero_a;
        a_fcol_reg     <= vertical_reg ? slot_j_reg : sub_h;
        a_bit_reg      <= u8[2:0];
        a_row_reg      <= slot_i_reg;
    end

    // Stage B: case fold in vertical mode, code check and font address.
    logic [7:0]         chr;
    logic               code_bad;
    logic [6:0]         glyph;
    logic [FONT_AW-1:0] font_raddr;

    always_comb
    begin
        chr = msg_rdata_reg;
        if (vertical_reg && (chr >= CHAR_LOWER_A) && (chr <= CHAR_LOWER_Z))
        begin
            chr = chr - CASE_FOLD;
        end
    end

    assign code_bad   = (chr < CHAR_FIRST) || (chr > CHAR_LAST);
    assign glyph      = 7'(chr - CHAR_FIRST);
    assign font_raddr = FONT_AW'({glyph, 2'b00}) + FONT_AW'(glyph) + FONT_AW'(a_fcol_reg);

    logic             b_valid_reg;
    logic             b_zero_row_reg;
    logic             b_zero_glyph_reg;
    logic [2:0]       b_fcol_reg;
    logic [2:0]       b_bit_reg;
    logic [ROW_W-1:0] b_row_reg;

    logic [7:0] font_mem [FONT_DEPTH];
    logic [7:0] font_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_font && (index < 9'(FONT_DEPTH)))
        begin
            font_mem[index] <= data_byte;
        end
        font_rdata_reg <= font_mem[font_raddr];
    end

    always_ff @(posedge clk)
    begin
        b_zero_row_reg   <= a_zero_row_reg;
        b_zero_glyph_reg <= code_bad;
        b_fcol_reg       <= a_fcol_reg;
        b_bit_reg        <= a_bit_reg;
        b_row_reg        <= a_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= cmd.issue_slot;
            b_valid_reg <= a_valid_reg;
        end
    end

    assign status.pipe_busy = a_valid_reg || b_valid_reg;

    // Stage C: write the glyph column into the frame.
    logic [7:0] glyph_col;
    logic [2:0] col_pos;
    logic [7:0] frame_reg  [FRAME_ROWS];
    logic [7:0] frame_next [FRAME_ROWS];

    assign glyph_col = (b_zero_row_reg || b_zero_glyph_reg) ? 8'd0 : font_rdata_reg;
    assign col_pos   = 3'(b_fcol_reg + {1'b0, column_offset_reg});

    always_comb
    begin
        logic [ROW_W-1:0] rel;
        rel        = '0;
        frame_next = frame_reg;
        if (cmd.restart)
        begin
            for (int fr = 0; fr < FRAME_ROWS; fr++)
            begin
                frame_next[fr] = '0;
            end
        end
        else if (b_valid_reg)
        begin
            if (vertical_reg)
            begin
                // A spacer or out-of-message row blanks all eight columns;
                // otherwise only the five glyph columns are touched.
                if (b_zero_row_reg)
                begin
                    frame_next[b_row_reg] = '0;
                end
                else
                begin
                    frame_next[b_row_reg][col_pos] = glyph_col[b_bit_reg];
                end
            end
            else
            begin
                for (int fr = 0; fr < FRAME_ROWS; fr++)
                begin
                    rel = ROW_W'(fr) - row_offset_reg;
                    if ((ROW_W'(fr) >= row_offset_reg) && (rel < ROW_W'(GLYPH_ROWS)))
                    begin
                        frame_next[fr][b_row_reg[2:0]] = glyph_col[rel[2:0]];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int fr = 0; fr < FRAME_ROWS; fr++)
            begin
                frame_reg[fr] <= '0;
            end
        end
        else
        begin
            frame_reg <= frame_next;
        end
    end

    // Emission of the frame through the output register.
    logic [ROW_W-1:0] emit_cnt_reg;
    logic             out_valid_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [7:0]       out_bits_reg;
    logic             out_last_reg;

    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.last_emit = (emit_cnt_reg == ROW_W'(FRAME_ROWS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_render || cmd.restart)
            begin
                emit_cnt_reg <= '0;
            end
            else if (cmd.emit_row)
            begin
                emit_cnt_reg <= emit_cnt_reg + ROW_W'(1);
            end
            if (cmd.emit_row)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_row)
        begin
            out_row_reg  <= emit_cnt_reg;
            out_bits_reg <= frame_reg[emit_cnt_reg];
            out_last_reg <= status.last_emit;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_number = out_row_reg;
    assign row_bits   = out_bits_reg;
    assign last_row   = out_last_reg;

endmodule

/* rtl/core/led_matrix_text_scroller.sv */
// LED matrix text scroller: scrolls a stored message over a 16 x 8 frame and
// emits the frame row by row. A tick runs the render slots (8 in horizontal
// mode, 80 in vertical mode: five font reads for each of the 16 frame rows),
// a pipeline drain, one position update and 16 row transfers; the single font
// memory read port, one read per slot, sets the render length. Row transfers
// wait while out_stall is held high. Message and font bytes read before they
// are written give undefined pixels; configuration is to be written only while
// the block is idle.
// Depends on lmts_pkg, lmts_ctrl and lmts_datapath.
module led_matrix_text_scroller
    import lmts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic [8:0]           index,
    input  logic [7:0]           data_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ROW_W-1:0]     row_number,
    output logic [7:0]           row_bits,
    output logic                 last_row,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    lmts_cmd_t    cmd;
    lmts_status_t status;

    lmts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    lmts_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .index      (index),
        .data_byte  (data_byte),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_number (row_number),
        .row_bits   (row_bits),
        .last_row   (last_row)
    );

endmodule

/* rtl/core/lmts_checker.sv */
// Port-level checker for the LED matrix text scroller, attached by bind.
// Depends on lmts_pkg and the top level led_matrix_text_scroller.
module lmts_checker
    import lmts_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [1:0]       command,
    input logic             out_valid,
    input logic             out_stall,
    input logic [ROW_W-1:0] row_number,
    input logic [7:0]       row_bits,
    input logic             last_row
);

    // A stalled row keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_number) && $stable(row_bits))
        else $error("stalled output row changed");

    // The end-of-frame flag marks the last row only.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_row == (row_number == ROW_W'(FRAME_ROWS - 1))))
        else $error("last_row does not match row_number");

    // Within a frame the next row is ready right after a transfer.
    a_frame_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_row |=> out_valid)
        else $error("gap inside a frame");

    // No new command is taken before the last row of a frame enters the output register.
    a_busy_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_row && (row_number != ROW_W'(FRAME_ROWS - 2))
        |=> in_stall)
        else $error("input taken in the middle of a frame");

    // A tick or restart occupies the block in the following cycle.
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && ((command == CMD_TICK) || (command == CMD_RESTART))
        |=> in_stall)
        else $error("frame command did not start work");

endmodule

bind led_matrix_text_scroller lmts_checker u_lmts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_number (row_number),
    .row_bits   (row_bits),
    .last_row   (last_row)
);
